### hw/rtl/psdd_pkg.sv
// types, codes and arithmetic helpers for the pointer swipe direction detector
`timescale 1ns / 1ps

package psdd_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_DIRECT = 2'd1;
   localparam logic [1:0] OP_ACCUM  = 2'd2;

   localparam logic [2:0] DIR_NONE  = 3'd0;
   localparam logic [2:0] DIR_RIGHT = 3'd1;
   localparam logic [2:0] DIR_LEFT  = 3'd2;
   localparam logic [2:0] DIR_DOWN  = 3'd3;
   localparam logic [2:0] DIR_UP    = 3'd4;

   localparam logic [1:0] CSR_TRIGGER_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_DEAD_ZONE         = 2'd1;
   localparam logic [1:0] CSR_DOMINANCE_PERCENT = 2'd2;

   localparam logic [30:0] TRIGGER_THRESHOLD_RESET = 31'd100;
   localparam logic [30:0] DEAD_ZONE_RESET         = 31'd0;
   localparam logic [7:0]  DOMINANCE_RESET         = 8'd150;
   localparam logic [7:0]  DOMINANCE_FLOOR         = 8'd50;
   localparam logic [6:0]  PERCENT_SCALE           = 7'd100;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic               sync;
      logic               shared_latch_in;
   } req_type;

   typedef struct packed {
      logic [2:0] direction;
      logic       latch_set;
   } rsp_type;

   // signed add clamped to the 32-bit range
   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         add_sat = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         add_sat = s[31:0];
      end
   endfunction

   // magnitude, most negative value counts as the largest positive one
   function automatic logic [30:0] mag(input logic signed [31:0] v);
      logic [31:0] n;
      n = 32'(-v);
      if (v == 32'sh8000_0000) begin
         mag = 31'h7FFF_FFFF;
      end else if (v[31]) begin
         mag = n[30:0];
      end else begin
         mag = v[30:0];
      end
   endfunction

   function automatic logic signed [31:0] sext16(input logic signed [31:0] v);
      sext16 = {{16{v[15]}}, v[15:0]};
   endfunction

endpackage

### hw/rtl/pointer_swipe_direction_detector.sv
// pointer swipe direction detector: motion totals, dead zone and dominance test
//
//  port group  | role      | handshake          | payload
//  req_        | motion in | req_valid/req_ready | req_data (req_type)
//  rsp_        | result    | rsp_valid/rsp_ready | rsp_data (rsp_type)
//  csr_        | registers | csr_write_en        | csr_index, csr_wdata
//
// one transaction per cycle sustained while results are taken; a transaction is
// held in the input register, then its result is presented from the output register
// the update and evaluation are combinational between the two registers
// reset clears the motion state and restores the register defaults
// a stalled result holds; the input register still fills behind it, and
// req_ready drops only when both registers are occupied
`timescale 1ns / 1ps

module pointer_swipe_direction_detector
   import psdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   logic [30:0] threshold_ff;
   logic [30:0] dead_zone_ff;
   logic [7:0]  dominance_ff;

   logic        in_valid_ff;
   req_type     in_data_ff;
   logic        out_valid_ff;
   rsp_type     out_data_ff;

   logic signed [31:0] total_x_ff, total_x_in;
   logic signed [31:0] total_y_ff, total_y_in;
   logic signed [31:0] pend_x_ff, pend_x_in;
   logic signed [31:0] pend_y_ff, pend_y_in;
   logic               fired_ff, fired_in;
   rsp_type            out_data_in;

   logic               out_free;
   logic               advance;

   logic signed [31:0] sum_x, sum_y;
   logic               eval_en;
   logic [30:0]        ax, ay, d;
   logic [7:0]         pct;
   logic [38:0]        ax_scaled, ay_scaled, ax_pct, ay_pct;
   logic               big_enough, dominant, fire;
   logic [2:0]         eval_dir;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // evaluation of the updated totals
   always_comb begin
      ax         = mag(total_x_in);
      ay         = mag(total_y_in);
      d          = (ax > ay) ? ax : ay;
      pct        = (dominance_ff < DOMINANCE_FLOOR) ? DOMINANCE_FLOOR : dominance_ff;
      ax_scaled  = {8'd0, ax} * {32'd0, PERCENT_SCALE};
      ay_scaled  = {8'd0, ay} * {32'd0, PERCENT_SCALE};
      ax_pct     = {8'd0, ax} * {31'd0, pct};
      ay_pct     = {8'd0, ay} * {31'd0, pct};
      big_enough = (d >= threshold_ff) && (d > dead_zone_ff);
      dominant   = !((ax_scaled < ay_pct) && (ay_scaled < ax_pct));
      fire       = eval_en && big_enough && dominant;
      if (!fire) begin
         eval_dir = DIR_NONE;
      end else if (ax >= ay) begin
         eval_dir = total_x_in[31] ? DIR_LEFT : DIR_RIGHT;
      end else begin
         eval_dir = total_y_in[31] ? DIR_UP : DIR_DOWN;
      end
   end

   // state update for the transaction in the input register
   always_comb begin
      total_x_in = total_x_ff;
      total_y_in = total_y_ff;
      pend_x_in  = pend_x_ff;
      pend_y_in  = pend_y_ff;
      eval_en    = 1'b0;
      sum_x      = add_sat(pend_x_ff, in_data_ff.delta_x);
      sum_y      = add_sat(pend_y_ff, in_data_ff.delta_y);
      unique case (in_data_ff.op)
         OP_CLEAR: begin
            total_x_in = '0;
            total_y_in = '0;
            pend_x_in  = '0;
            pend_y_in  = '0;
         end
         OP_DIRECT: begin
            if (!fired_ff) begin
               total_x_in = add_sat(total_x_ff, sext16(in_data_ff.delta_x));
               total_y_in = add_sat(total_y_ff, sext16(in_data_ff.delta_y));
               eval_en    = 1'b1;
            end
         end
         OP_ACCUM: begin
            if (!fired_ff && !in_data_ff.shared_latch_in) begin
               if (in_data_ff.sync) begin
                  pend_x_in = '0;
                  pend_y_in = '0;
                  if (mag(sum_x) > dead_zone_ff || mag(sum_y) > dead_zone_ff) begin
                     total_x_in = add_sat(total_x_ff, sum_x);
                     total_y_in = add_sat(total_y_ff, sum_y);
                     eval_en    = 1'b1;
                  end
               end else begin
                  pend_x_in = sum_x;
                  pend_y_in = sum_y;
               end
            end
         end
         default: begin
         end
      endcase
      fired_in = (in_data_ff.op == OP_CLEAR) ? 1'b0 : (fired_ff || fire);
      out_data_in.direction = eval_dir;
      out_data_in.latch_set = fire && (in_data_ff.op == OP_ACCUM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= TRIGGER_THRESHOLD_RESET;
         dead_zone_ff <= DEAD_ZONE_RESET;
         dominance_ff <= DOMINANCE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TRIGGER_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_DEAD_ZONE:         dead_zone_ff <= csr_wdata;
            CSR_DOMINANCE_PERCENT: dominance_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         total_x_ff   <= '0;
         total_y_ff   <= '0;
         pend_x_ff    <= '0;
         pend_y_ff    <= '0;
         fired_ff     <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            total_x_ff   <= total_x_in;
            total_y_ff   <= total_y_in;
            pend_x_ff    <= pend_x_in;
            pend_y_ff    <= pend_y_in;
            fired_ff     <= fired_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
